FILE: design/dmc_pkg.sv
// shared types and constants for the dmc control step block
// no dependencies; used by dmc_ctrl, dmc_datapath and the top level
package dmc_pkg;

   localparam int HIST_LEN_DEF = 63;

   localparam int DATA_W     = 16;
   localparam int COEF_W     = 18;
   localparam int IDX_W      = 6;
   localparam int DIFF_W     = DATA_W + 1;
   localparam int PROD_W     = COEF_W + DIFF_W;
   localparam int ACC_W      = 44;
   localparam int FRAC_SHIFT = 12;
   localparam int RND_W      = ACC_W - FRAC_SHIFT;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ERROR_GAIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_MIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_MAX  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_MIN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_MAX   = 3'd4;

   // request kinds
   localparam logic ACT_STEP = 1'b0;
   localparam logic ACT_LOAD = 1'b1;

   typedef struct packed {
      logic signed [COEF_W-1:0] error_gain;
      logic signed [DATA_W-1:0] drive_min;
      logic signed [DATA_W-1:0] drive_max;
      logic signed [DATA_W-1:0] step_min;
      logic signed [DATA_W-1:0] step_max;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic start;
      logic issue;
      logic round;
      logic clamp;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } status_type;

endpackage

FILE: design/dmc_ctrl.sv
// sequencer for the dmc control step: request acceptance, mac sweep, finish stages
// depends on dmc_pkg (cmd_type, status_type, request kinds)
module dmc_ctrl #(
   parameter int HIST_LEN = dmc_pkg::HIST_LEN_DEF,
   parameter int AW       = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_action,
   output logic                req_ready,
   input  dmc_pkg::status_type status,
   output dmc_pkg::cmd_type    cmd,
   output logic [AW-1:0]       rd_idx
);

   localparam logic [AW-1:0] LAST_IDX = AW'(HIST_LEN - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN1,
      ST_DRAIN2,
      ST_ROUND,
      ST_CLAMP,
      ST_COMMIT
   } state_type;

   state_type       state_ff;
   logic [AW-1:0]   idx_ff;
   logic            accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rd_idx    = idx_ff;

   always_comb begin
      cmd        = '0;
      cmd.load   = accept && (req_action == dmc_pkg::ACT_LOAD);
      cmd.start  = accept && (req_action == dmc_pkg::ACT_STEP);
      cmd.issue  = (state_ff == ST_MAC);
      cmd.round  = (state_ff == ST_ROUND);
      cmd.clamp  = (state_ff == ST_CLAMP);
      cmd.commit = (state_ff == ST_COMMIT) && !status.out_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               idx_ff <= '0;
               if (cmd.start) begin
                  state_ff <= ST_MAC;
               end
            end
            ST_MAC: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == LAST_IDX) begin
                  state_ff <= ST_DRAIN1;
               end
            end
            ST_DRAIN1: state_ff <= ST_DRAIN2;
            ST_DRAIN2: state_ff <= ST_ROUND;
            ST_ROUND:  state_ff <= ST_CLAMP;
            ST_CLAMP:  state_ff <= ST_COMMIT;
            ST_COMMIT: begin
               if (!status.out_busy) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

FILE: design/dmc_datapath.sv
// datapath of the dmc control step: coefficient and history memories, shared
// multiplier, accumulator, rounding, clamps, drive register and result register
// depends on dmc_pkg (cfg_type, cmd_type, status_type, widths)
module dmc_datapath #(
   parameter int HIST_LEN = dmc_pkg::HIST_LEN_DEF,
   parameter int AW       = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dmc_pkg::cmd_type                     cmd,
   input  logic [AW-1:0]                        rd_idx,
   input  dmc_pkg::cfg_type                     cfg,
   input  logic signed [dmc_pkg::DATA_W-1:0]    measured,
   input  logic signed [dmc_pkg::DATA_W-1:0]    setpoint,
   input  logic [dmc_pkg::IDX_W-1:0]            coef_index,
   input  logic signed [dmc_pkg::COEF_W-1:0]    coef_value,
   output dmc_pkg::status_type                  status,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [dmc_pkg::DATA_W-1:0]    drive,
   output logic signed [dmc_pkg::DATA_W-1:0]    increment
);

   localparam int DW = dmc_pkg::DATA_W;
   localparam int CW = dmc_pkg::COEF_W;
   localparam int XW = dmc_pkg::DIFF_W;
   localparam int PW = dmc_pkg::PROD_W;
   localparam int AccW = dmc_pkg::ACC_W;
   localparam int RW = dmc_pkg::RND_W;
   localparam int IW = dmc_pkg::IDX_W;
   localparam int FW = $clog2(HIST_LEN + 1);
   localparam logic [AW-1:0] LAST_IDX = AW'(HIST_LEN - 1);
   localparam logic [FW-1:0] FULL_CNT = FW'(HIST_LEN);
   localparam logic [AccW-1:0] HALF_LSB = AccW'(1) << (dmc_pkg::FRAC_SHIFT - 1);

   logic signed [CW-1:0] coef_mem [HIST_LEN];
   logic signed [DW-1:0] hist_mem [HIST_LEN];

   logic signed [CW-1:0]   coef_rd_ff;
   logic signed [DW-1:0]   hist_rd_ff;
   logic                   hist_ok_ff;
   logic                   mac1_ff, mac2_ff, err1_ff, err2_ff;
   logic signed [XW-1:0]   diff_ff;
   logic signed [PW-1:0]   prod_ff;
   logic signed [PW-1:0]   prod_in;
   logic signed [CW-1:0]   mult_a;
   logic signed [XW-1:0]   mult_b;
   logic signed [AccW-1:0] acc_ff;
   logic signed [AccW-1:0] prod_ext;
   logic signed [AccW-1:0] acc_rnd;
   logic signed [RW-1:0]   rnd_ff;
   logic signed [DW-1:0]   sat_val;
   logic signed [DW-1:0]   inc_ff, inc_in;
   logic signed [DW-1:0]   drive_ff, drive_in;
   logic signed [DW:0]     drive_sum;
   logic [AW-1:0]          newest_ff, wr_ptr, rd_ptr_ff;
   logic [FW-1:0]          fill_ff;
   logic                   rsp_valid_ff;
   logic signed [DW-1:0]   rsp_drive_ff, rsp_inc_ff;
   logic [IW+AW-1:0]       load_idx_ext;
   logic [AW-1:0]          load_addr;
   logic                   load_ok;

   // load address, taken from the request index at whichever width the depth needs
   assign load_idx_ext = {{AW{1'b0}}, coef_index};
   assign load_addr    = load_idx_ext[AW-1:0];
   assign load_ok      = {{AW{1'b0}}, coef_index} < (IW+AW)'(HIST_LEN);

   assign wr_ptr = (newest_ff == LAST_IDX) ? '0 : newest_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.load && load_ok) begin
         coef_mem[load_addr] <= coef_value;
      end
      if (cmd.issue) begin
         coef_rd_ff <= coef_mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         hist_mem[wr_ptr] <= inc_ff;
      end
      if (cmd.issue) begin
         hist_rd_ff <= hist_mem[rd_ptr_ff];
      end
   end

   // history read pointer walks from newest to oldest
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rd_ptr_ff <= newest_ff;
         diff_ff   <= {setpoint[DW-1], setpoint} - {measured[DW-1], measured};
      end else if (cmd.issue) begin
         rd_ptr_ff <= (rd_ptr_ff == '0) ? LAST_IDX : rd_ptr_ff - 1'b1;
      end
      if (cmd.issue) begin
         hist_ok_ff <= FW'(rd_idx) < fill_ff;
      end
   end

   // shared multiplier: error term first, then one history product per cycle
   assign mult_a  = err1_ff ? cfg.error_gain : coef_rd_ff;
   assign mult_b  = err1_ff ? diff_ff
                  : (hist_ok_ff ? {hist_rd_ff[DW-1], hist_rd_ff} : '0);
   assign prod_in = mult_a * mult_b;
   assign prod_ext = {{(AccW-PW){prod_ff[PW-1]}}, prod_ff};
   assign acc_rnd  = acc_ff + HALF_LSB;

   always_ff @(posedge clock) begin
      if (reset) begin
         mac1_ff <= 1'b0;
         mac2_ff <= 1'b0;
         err1_ff <= 1'b0;
         err2_ff <= 1'b0;
      end else begin
         mac1_ff <= cmd.issue;
         mac2_ff <= mac1_ff;
         err1_ff <= cmd.start;
         err2_ff <= err1_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (err2_ff) begin
         acc_ff <= prod_ext;
      end else if (mac2_ff) begin
         acc_ff <= acc_ff - prod_ext;
      end
      if (cmd.round) begin
         rnd_ff <= acc_rnd[AccW-1:dmc_pkg::FRAC_SHIFT];
      end
      if (cmd.clamp) begin
         inc_ff <= inc_in;
      end
   end

   // saturate to q8.8, then the step clamp, lower bound first
   always_comb begin
      if (rnd_ff[RW-1:DW-1] == '0 || rnd_ff[RW-1:DW-1] == '1) begin
         sat_val = rnd_ff[DW-1:0];
      end else begin
         sat_val = rnd_ff[RW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      end
      priority if (sat_val < cfg.step_min) begin
         inc_in = cfg.step_min;
      end else if (sat_val > cfg.step_max) begin
         inc_in = cfg.step_max;
      end else begin
         inc_in = sat_val;
      end
   end

   // drive clamp, lower bound first, then back into 16 bits
   always_comb begin
      drive_sum = {drive_ff[DW-1], drive_ff} + {inc_ff[DW-1], inc_ff};
      priority if (drive_sum < $signed({cfg.drive_min[DW-1], cfg.drive_min})) begin
         drive_in = cfg.drive_min;
      end else if (drive_sum > $signed({cfg.drive_max[DW-1], cfg.drive_max})) begin
         drive_in = cfg.drive_max;
      end else if (drive_sum[DW] != drive_sum[DW-1]) begin
         drive_in = drive_sum[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      end else begin
         drive_in = drive_sum[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_ff     <= '0;
         newest_ff    <= LAST_IDX;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            drive_ff     <= drive_in;
            newest_ff    <= wr_ptr;
            rsp_valid_ff <= 1'b1;
            if (fill_ff != FULL_CNT) begin
               fill_ff <= fill_ff + 1'b1;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_drive_ff <= drive_in;
         rsp_inc_ff   <= inc_ff;
      end
   end

   assign status.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign drive           = rsp_drive_ff;
   assign increment       = rsp_inc_ff;

endmodule

FILE: design/dynamic_matrix_control_step.sv
// dmc online control step: a step request raises rsp_tvalid once the mac sweep over
// the history and the drain, round, clamp and commit states are through, and the next
// request is taken no sooner; load requests are taken one per cycle while idle
// the step time is set by the single multiplier, one history product per cycle
// reset clears drive, fill count, rsp_tvalid and error gain, clamps go to full range;
// coefficients are undefined until loaded, history reads as zero until written
module dynamic_matrix_control_step #(
   parameter int HIST_LEN = dmc_pkg::HIST_LEN_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // measured [15:0], setpoint [31:16], coef_index [37:32], coef_value [55:38]
   input  logic [dmc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // action [0]: step or coefficient load
   input  logic                               req_tuser,
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // drive [15:0], increment [31:16]
   output logic [dmc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // register write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [dmc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dmc_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int AW = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
   localparam int DW = dmc_pkg::DATA_W;

   dmc_pkg::cfg_type    cfg_ff;
   dmc_pkg::cmd_type    cmd;
   dmc_pkg::status_type status;
   logic [AW-1:0]       rd_idx;
   logic signed [DW-1:0] rsp_drive, rsp_inc;

   // register writes are always taken; unknown indexes fall away
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.error_gain <= '0;
         cfg_ff.drive_min  <= {1'b1, {(DW-1){1'b0}}};
         cfg_ff.drive_max  <= {1'b0, {(DW-1){1'b1}}};
         cfg_ff.step_min   <= {1'b1, {(DW-1){1'b0}}};
         cfg_ff.step_max   <= {1'b0, {(DW-1){1'b1}}};
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dmc_pkg::CSR_ERROR_GAIN: cfg_ff.error_gain <= csr_data;
            dmc_pkg::CSR_DRIVE_MIN:  cfg_ff.drive_min  <= csr_data[DW-1:0];
            dmc_pkg::CSR_DRIVE_MAX:  cfg_ff.drive_max  <= csr_data[DW-1:0];
            dmc_pkg::CSR_STEP_MIN:   cfg_ff.step_min   <= csr_data[DW-1:0];
            dmc_pkg::CSR_STEP_MAX:   cfg_ff.step_max   <= csr_data[DW-1:0];
            default: ;
         endcase
      end
   end

   // sequencer: idle, mac sweep over the history, drain, round, clamp, commit
   dmc_ctrl #(
      .HIST_LEN (HIST_LEN),
      .AW       (AW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_action (req_tuser),
      .req_ready  (req_tready),
      .status     (status),
      .cmd        (cmd),
      .rd_idx     (rd_idx)
   );

   // memories, multiply-accumulate, clamps and the result register
   dmc_datapath #(
      .HIST_LEN (HIST_LEN),
      .AW       (AW)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .rd_idx     (rd_idx),
      .cfg        (cfg_ff),
      .measured   (req_tdata[15:0]),
      .setpoint   (req_tdata[31:16]),
      .coef_index (req_tdata[37:32]),
      .coef_value (req_tdata[55:38]),
      .status     (status),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .drive      (rsp_drive),
      .increment  (rsp_inc)
   );

   // response packing, drive in the low half
   assign rsp_tdata = {rsp_inc, rsp_drive};

endmodule
